### rtl/core/cafc_pkg.sv
// shared types and constants for the acknowledge frame checker
// no dependencies; the other files that use it refer to this package by scoped names

package cafc_pkg;

	localparam int MAX_VALUE_BYTES = 32;
	localparam int IDX_W = (MAX_VALUE_BYTES > 1) ? $clog2(MAX_VALUE_BYTES) : 1;
	localparam int CNT_W = $clog2(MAX_VALUE_BYTES + 1);

	localparam logic [7:0]  FIXED_BYTES   = 8'd10;
	localparam logic [15:0] MIN_PAYLOAD   = 16'd4;
	localparam logic [15:0] MAX_PAYLOAD   = 16'(4 + MAX_VALUE_BYTES);
	localparam logic [7:0]  MIN_FRAME     = 8'd6;
	localparam logic [31:0] TRAILER_WORD  = 32'h0403_0201;
	localparam logic [15:0] ACK_BIT       = 16'h0100;

	localparam logic [7:0] POS_LEN_LO  = 8'd4;
	localparam logic [7:0] POS_LEN_HI  = 8'd5;
	localparam logic [7:0] POS_CMD_LO  = 8'd6;
	localparam logic [7:0] POS_CMD_HI  = 8'd7;
	localparam logic [7:0] POS_STS_LO  = 8'd8;
	localparam logic [7:0] POS_STS_HI  = 8'd9;
	localparam logic [7:0] POS_SAT     = 8'hFF;

	typedef enum logic [1:0] {
		ACK_VALID     = 2'd0,
		ACK_INVALID   = 2'd1,
		ACK_WRONG_CMD = 2'd2,
		ACK_FAILED    = 2'd3
	} ack_status_t;

	typedef enum logic [1:0] {
		ST_COLLECT,
		ST_JUDGE,
		ST_EMIT
	} cafc_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic judge;
		logic load_value;
		logic load_status;
		logic clear;
	} cafc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rem_zero;
		logic out_free;
	} cafc_sts_t;

	function automatic logic [7:0] hdr_byte(input logic [1:0] pos);
		logic [7:0] b;
		unique case (pos)
			2'd0: b = 8'hFD;
			2'd1: b = 8'hFC;
			2'd2: b = 8'hFB;
			default: b = 8'hFA;
		endcase
		return b;
	endfunction

endpackage

### rtl/core/cafc_if.sv
// valid/ready channel interfaces for frame bytes in and ack items out
// no dependencies

interface cafc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_frame;

	modport source (output valid, output byte_in, output end_of_frame, input ready);
	modport sink (input valid, input byte_in, input end_of_frame, output ready);
endinterface

interface cafc_out_if;
	logic       valid;
	logic       ready;
	logic       is_value;
	logic [7:0] value_byte;
	logic [1:0] ack_status;
	logic       last;

	modport source (output valid, output is_value, output value_byte, output ack_status,
		output last, input ready);
	modport sink (input valid, input is_value, input value_byte, input ack_status,
		input last, output ready);
endinterface

### rtl/core/cafc_datapath.sv
// frame field capture, value buffer, judgment and output register
// depends on cafc_pkg

module cafc_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cafc_pkg::cafc_cmd_t  cmd,
	output cafc_pkg::cafc_sts_t  sts,
	input  logic [7:0]           byte_in,
	input  logic                 cfg_wr_en,
	input  logic [15:0]          cfg_wr_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 is_value,
	output logic [7:0]           value_byte,
	output logic [1:0]           ack_status,
	output logic                 last
);

	logic [15:0] await_cmd_q;
	logic [7:0]  byte_position_q;
	logic        header_mismatch_q;
	logic [15:0] payload_length_q;
	logic [15:0] echoed_command_q;
	logic [15:0] status_word_q;
	logic [31:0] tail_window_q;
	logic [7:0]  value_store [cafc_pkg::MAX_VALUE_BYTES];

	cafc_pkg::ack_status_t       st_q;
	logic [cafc_pkg::CNT_W-1:0]  rem_q;
	logic [cafc_pkg::IDX_W-1:0]  rd_idx_q;

	logic        out_valid_q;
	logic        is_value_q;
	logic [7:0]  value_byte_q;
	logic [1:0]  ack_status_q;
	logic        last_q;

	logic [7:0]  store_off;
	logic        store_hit;
	cafc_pkg::ack_status_t judge_st;
	logic [15:0] plen_minus;

	assign store_off = byte_position_q - cafc_pkg::FIXED_BYTES;
	assign store_hit = (byte_position_q >= cafc_pkg::FIXED_BYTES) &&
		(9'(store_off) < 9'(cafc_pkg::MAX_VALUE_BYTES));
	assign plen_minus = payload_length_q - cafc_pkg::MIN_PAYLOAD;

	// byte_position already counts the final byte, so it equals the frame length
	// for every length that can pass
	always_comb begin
		if (byte_position_q < cafc_pkg::MIN_FRAME || header_mismatch_q ||
			payload_length_q < cafc_pkg::MIN_PAYLOAD ||
			payload_length_q > cafc_pkg::MAX_PAYLOAD ||
			16'(byte_position_q) != payload_length_q + 16'(cafc_pkg::FIXED_BYTES) ||
			tail_window_q != cafc_pkg::TRAILER_WORD) begin
			judge_st = cafc_pkg::ACK_INVALID;
		end else if (echoed_command_q != (await_cmd_q | cafc_pkg::ACK_BIT)) begin
			judge_st = cafc_pkg::ACK_WRONG_CMD;
		end else if (status_word_q != 16'd0) begin
			judge_st = cafc_pkg::ACK_FAILED;
		end else begin
			judge_st = cafc_pkg::ACK_VALID;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			await_cmd_q <= '0;
		end else if (cfg_wr_en) begin
			await_cmd_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q   <= '0;
			header_mismatch_q <= 1'b0;
			payload_length_q  <= '0;
			echoed_command_q  <= '0;
			status_word_q     <= '0;
			tail_window_q     <= '0;
		end else if (cmd.clear) begin
			byte_position_q   <= '0;
			header_mismatch_q <= 1'b0;
			payload_length_q  <= '0;
			echoed_command_q  <= '0;
			status_word_q     <= '0;
			tail_window_q     <= '0;
		end else if (cmd.take) begin
			if (byte_position_q != cafc_pkg::POS_SAT) begin
				byte_position_q <= byte_position_q + 8'd1;
			end
			tail_window_q <= {tail_window_q[23:0], byte_in};
			if (byte_position_q < cafc_pkg::POS_LEN_LO) begin
				if (byte_in != cafc_pkg::hdr_byte(byte_position_q[1:0])) begin
					header_mismatch_q <= 1'b1;
				end
			end
			if (byte_position_q == cafc_pkg::POS_LEN_LO) payload_length_q[7:0]  <= byte_in;
			if (byte_position_q == cafc_pkg::POS_LEN_HI) payload_length_q[15:8] <= byte_in;
			if (byte_position_q == cafc_pkg::POS_CMD_LO) echoed_command_q[7:0]  <= byte_in;
			if (byte_position_q == cafc_pkg::POS_CMD_HI) echoed_command_q[15:8] <= byte_in;
			if (byte_position_q == cafc_pkg::POS_STS_LO) status_word_q[7:0]     <= byte_in;
			if (byte_position_q == cafc_pkg::POS_STS_HI) status_word_q[15:8]    <= byte_in;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && store_hit) begin
			value_store[store_off[cafc_pkg::IDX_W-1:0]] <= byte_in;
		end
	end

	// only a valid frame releases its value bytes; length is in range then
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= cafc_pkg::ACK_VALID;
			rem_q    <= '0;
			rd_idx_q <= '0;
		end else if (cmd.judge) begin
			st_q     <= judge_st;
			rem_q    <= (judge_st == cafc_pkg::ACK_VALID) ? plen_minus[cafc_pkg::CNT_W-1:0] : '0;
			rd_idx_q <= '0;
		end else if (cmd.load_value) begin
			rem_q    <= rem_q - 1'b1;
			rd_idx_q <= rd_idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_value || cmd.load_status) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_value) begin
			is_value_q   <= 1'b1;
			value_byte_q <= value_store[rd_idx_q];
			ack_status_q <= cafc_pkg::ACK_VALID;
			last_q       <= 1'b0;
		end else if (cmd.load_status) begin
			is_value_q   <= 1'b0;
			value_byte_q <= 8'd0;
			ack_status_q <= st_q;
			last_q       <= 1'b1;
		end
	end

	assign sts.rem_zero = (rem_q == '0);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign is_value   = is_value_q;
	assign value_byte = value_byte_q;
	assign ack_status = ack_status_q;
	assign last       = last_q;

	// a beat may only be loaded over a slot that is empty or draining
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_value || cmd.load_status) |-> sts.out_free)
		else $error("output register overwritten while stalled");

	// value beats are never released for a frame judged bad
	a_value_valid_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_value |-> (st_q == cafc_pkg::ACK_VALID))
		else $error("value beat released for rejected frame");

	// a status beat always closes with last set
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_status |=> (last_q && !is_value_q && out_valid_q))
		else $error("status beat malformed");

endmodule

### rtl/core/cafc_ctrl.sv
// controller state machine: collects bytes, triggers judgment, sequences beats
// depends on cafc_pkg

module cafc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 end_of_frame,
	output logic                 in_ready,
	output cafc_pkg::cafc_cmd_t  cmd,
	input  cafc_pkg::cafc_sts_t  sts
);

	cafc_pkg::cafc_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cafc_pkg::ST_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			cafc_pkg::ST_COLLECT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					if (end_of_frame) state_d = cafc_pkg::ST_JUDGE;
				end
			end
			cafc_pkg::ST_JUDGE: begin
				cmd.judge = 1'b1;
				state_d   = cafc_pkg::ST_EMIT;
			end
			cafc_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					if (sts.rem_zero) begin
						cmd.load_status = 1'b1;
						cmd.clear       = 1'b1;
						state_d         = cafc_pkg::ST_COLLECT;
					end else begin
						cmd.load_value = 1'b1;
					end
				end
			end
			default: state_d = cafc_pkg::ST_COLLECT;
		endcase
	end

	a_judge_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cafc_pkg::ST_JUDGE) |=> (state_q == cafc_pkg::ST_EMIT))
		else $error("judgment not followed by emission");

	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cafc_pkg::ST_COLLECT) |-> !cmd.take)
		else $error("byte taken while frame in flight");

	a_status_closes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_status |=> (state_q == cafc_pkg::ST_COLLECT))
		else $error("frame not closed after status beat");

endmodule

### rtl/core/command_ack_frame_checker.sv
// top level of the acknowledge frame checker
// depends on cafc_pkg, cafc_if, cafc_ctrl and cafc_datapath
//
//   port        dir   beat contents
//   frame_in    in    byte_in[7:0], end_of_frame
//   ack_out     out   is_value, value_byte[7:0], ack_status[1:0], last
//   cfg_wr_*    in    awaited command[15:0], written when cfg_wr_en is high
//
// one byte per cycle while a frame is being collected; the final byte is followed
// by a judgment state, then one beat per returned value byte plus one status
// beat, paced by the single output register and by ack_out.ready
// no bytes are taken from the final byte until the status beat is loaded
// arst_n clears the controller, frame fields and output valid; no clearing pass

module command_ack_frame_checker (
	input  logic         clk,
	input  logic         arst_n,
	cafc_in_if.sink      frame_in,
	cafc_out_if.source   ack_out,
	input  logic         cfg_wr_en,
	input  logic [15:0]  cfg_wr_data
);

	cafc_pkg::cafc_cmd_t cmd;
	cafc_pkg::cafc_sts_t sts;

	cafc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (frame_in.valid),
		.end_of_frame (frame_in.end_of_frame),
		.in_ready     (frame_in.ready),
		.cmd          (cmd),
		.sts          (sts)
	);

	cafc_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.byte_in     (frame_in.byte_in),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (ack_out.valid),
		.out_ready   (ack_out.ready),
		.is_value    (ack_out.is_value),
		.value_byte  (ack_out.value_byte),
		.ack_status  (ack_out.ack_status),
		.last        (ack_out.last)
	);

endmodule
